[sv/psa_pkg.sv]
// ----------------------------------------------------------------------------
// psa_pkg
// shared types and constants of the pwm sensor pulse averager
// ----------------------------------------------------------------------------
`default_nettype none

package psa_pkg;

    localparam int TIME_W     = 32;
    localparam int VAL_W      = 16;
    localparam int READING_W  = 18;
    localparam int OFFSET_W   = 4;
    localparam int SCALE_W    = 3;
    localparam int PROD_W     = VAL_W + SCALE_W + 1;
    localparam int AVG_SHIFT  = 3;

    localparam int VAL_MIN     = -32768;
    localparam int VAL_MAX     = 32767;
    localparam int READING_MIN = -131072;
    localparam int READING_MAX = 131071;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam int HISTORY_DEPTH_DEF = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER = 2'd2;

    localparam logic [OFFSET_W-1:0] OFFSET_RST = 4'd2;
    localparam logic [SCALE_W-1:0]  SCALE_RST  = 3'd1;
    localparam logic                FILTER_RST = 1'b1;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset_ms;
        logic [SCALE_W-1:0]  scale;
        logic                filter_enable;
    } t_cfg;

    typedef struct packed {
        logic                    valid;
        logic signed [VAL_W-1:0] value;
    } t_width_item;

endpackage

`default_nettype wire

[sv/psa_front.sv]
// ----------------------------------------------------------------------------
// psa_front
// edge capture: holds the rising edge time, turns a falling edge into an
// offset-corrected, saturated 16-bit width in the input register
// ----------------------------------------------------------------------------
`default_nettype none

module psa_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_accept,
    input  wire logic                              i_level,
    input  wire logic [psa_pkg::TIME_W-1:0]        i_time,
    input  wire logic [psa_pkg::OFFSET_W-1:0]      i_offset,
    input  wire logic                              i_take,
    output psa_pkg::t_width_item                   o_item
);

    localparam int DIFF_W = psa_pkg::TIME_W + 2;

    logic [psa_pkg::TIME_W-1:0]            r_pulse_start;
    logic                                  r_valid;
    logic signed [psa_pkg::VAL_W-1:0]      r_value;

    logic [psa_pkg::TIME_W-1:0]            width;
    logic signed [DIFF_W-1:0]              diff;
    logic signed [psa_pkg::VAL_W-1:0]      n_value;

    assign width = i_time - r_pulse_start;
    assign diff  = $signed({2'b00, width}) - $signed(DIFF_W'(i_offset));

    always_comb begin
        if (diff < DIFF_W'(psa_pkg::VAL_MIN)) begin
            n_value = psa_pkg::VAL_W'(psa_pkg::VAL_MIN);
        end else if (diff > DIFF_W'(psa_pkg::VAL_MAX)) begin
            n_value = psa_pkg::VAL_W'(psa_pkg::VAL_MAX);
        end else begin
            n_value = diff[psa_pkg::VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_start <= '0;
            r_valid       <= 1'b0;
        end else begin
            if (i_accept && i_level) begin
                r_pulse_start <= i_time;
            end
            if (i_accept && !i_level) begin
                r_valid <= 1'b1;
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && !i_level) begin
            r_value <= n_value;
        end
    end

    assign o_item.valid = r_valid;
    assign o_item.value = r_value;

endmodule

`default_nettype wire

[sv/psa_avg.sv]
// ----------------------------------------------------------------------------
// psa_avg
// scaling, moving average over the history line with a running sum, and
// the result register
// ----------------------------------------------------------------------------
`default_nettype none

module psa_avg #(
    parameter int HISTORY_DEPTH = psa_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire psa_pkg::t_width_item               i_item,
    input  wire psa_pkg::t_cfg                      i_cfg,
    input  wire logic                               i_load,
    output logic                                    o_valid,
    output logic signed [psa_pkg::READING_W-1:0]    o_reading,
    output logic                                    o_warming_up
);

    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W = psa_pkg::READING_W + CNT_W;
    localparam int RW    = psa_pkg::READING_W;
    localparam int PW    = psa_pkg::PROD_W;

    logic signed [RW-1:0]     r_hist [HISTORY_DEPTH];
    logic [CNT_W-1:0]         r_count;
    logic signed [SUM_W-1:0]  r_hist_sum;
    logic                     r_valid;
    logic signed [RW-1:0]     r_reading;
    logic                     r_warm;

    logic signed [PW-1:0]     prod;
    logic signed [RW-1:0]     scaled;
    logic                     full;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  avg_wide;
    logic signed [RW-1:0]     avg;
    logic signed [SUM_W-1:0]  n_hist_sum;
    logic signed [RW-1:0]     n_reading;
    logic                     n_warm;
    logic                     take;

    assign take = i_load && i_item.valid;
    assign prod = PW'($signed(i_item.value)) * PW'($signed({1'b0, i_cfg.scale}));

    always_comb begin
        if (prod < PW'(psa_pkg::READING_MIN)) begin
            scaled = RW'(psa_pkg::READING_MIN);
        end else if (prod > PW'(psa_pkg::READING_MAX)) begin
            scaled = RW'(psa_pkg::READING_MAX);
        end else begin
            scaled = prod[RW-1:0];
        end
    end

    assign full     = (r_count == CNT_W'(HISTORY_DEPTH));
    assign sum      = r_hist_sum + SUM_W'(scaled);
    assign avg_wide = sum >>> psa_pkg::AVG_SHIFT;

    always_comb begin
        if (avg_wide < SUM_W'(psa_pkg::READING_MIN)) begin
            avg = RW'(psa_pkg::READING_MIN);
        end else if (avg_wide > SUM_W'(psa_pkg::READING_MAX)) begin
            avg = RW'(psa_pkg::READING_MAX);
        end else begin
            avg = avg_wide[RW-1:0];
        end
    end

    always_comb begin
        n_hist_sum = sum;
        n_reading  = scaled;
        n_warm     = 1'b0;
        if (i_cfg.filter_enable) begin
            if (full) begin
                n_hist_sum = sum - SUM_W'(r_hist[0]);
                n_reading  = avg;
            end else begin
                n_warm = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_hist_sum <= '0;
            r_valid    <= 1'b0;
        end else begin
            if (i_load) begin
                r_valid <= i_item.valid;
            end
            if (take && i_cfg.filter_enable) begin
                r_hist_sum <= n_hist_sum;
                if (!full) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
        end
    end

    // history line, newest at the top, oldest leaves from entry zero
    always_ff @(posedge i_clk) begin
        if (take && i_cfg.filter_enable) begin
            for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
                r_hist[i] <= r_hist[i + 1];
            end
            r_hist[HISTORY_DEPTH - 1] <= scaled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_reading <= n_reading;
            r_warm    <= n_warm;
        end
    end

    assign o_valid      = r_valid;
    assign o_reading    = r_reading;
    assign o_warming_up = r_warm;

endmodule

`default_nettype wire

[sv/pwm_sensor_pulse_averager.sv]
// ----------------------------------------------------------------------------
// pwm_sensor_pulse_averager
// pulse width measurement of a pwm sensor output with an optional
// eight-sample moving average
// ----------------------------------------------------------------------------
// a falling edge result is held in the input register, then in the result register
// throughput: one edge per cycle unless the output stalls, via input and result registers
// rising edges give no result and only update the stored start time
// reset (synchronous, active low) clears start time, fill count, running
// sum and handshake state; registers return to offset 2, scale 1, filter on
`default_nettype none

module pwm_sensor_pulse_averager #(
    parameter int HISTORY_DEPTH = psa_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [psa_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // time_ms
    input  wire logic                              s_axis_tuser,  // pin_level
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [psa_pkg::M_TDATA_W-1:0]          m_axis_tdata,  // reading, zero pad
    output logic                                   m_axis_tuser,  // warming_up
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [psa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [psa_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    psa_pkg::t_cfg                              r_cfg;
    psa_pkg::t_width_item                       item;
    logic                                       accept;
    logic                                       out_load;
    logic                                       take;
    logic                                       out_valid;
    logic signed [psa_pkg::READING_W-1:0]       reading;
    logic                                       warm;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_ms     <= psa_pkg::OFFSET_RST;
            r_cfg.scale         <= psa_pkg::SCALE_RST;
            r_cfg.filter_enable <= psa_pkg::FILTER_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                psa_pkg::CFG_OFFSET: r_cfg.offset_ms <= i_cfg_data[psa_pkg::OFFSET_W-1:0];
                psa_pkg::CFG_SCALE:  r_cfg.scale <= i_cfg_data[psa_pkg::SCALE_W-1:0];
                psa_pkg::CFG_FILTER: r_cfg.filter_enable <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign out_load      = !out_valid || m_axis_tready;
    assign take          = item.valid && out_load;
    assign s_axis_tready = !item.valid || out_load;
    assign accept        = s_axis_tvalid && s_axis_tready;

    psa_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_level  (s_axis_tuser),
        .i_time   (s_axis_tdata),
        .i_offset (r_cfg.offset_ms),
        .i_take   (take),
        .o_item   (item)
    );

    psa_avg #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_avg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_cfg        (r_cfg),
        .i_load       (out_load),
        .o_valid      (out_valid),
        .o_reading    (reading),
        .o_warming_up (warm)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {{(psa_pkg::M_TDATA_W - psa_pkg::READING_W){1'b0}}, reading};
    assign m_axis_tuser  = warm;

endmodule

`default_nettype wire

[sv/psa_checker.sv]
// ----------------------------------------------------------------------------
// psa_checker
// port-level checks of the pwm sensor pulse averager, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module psa_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    input  wire logic                              s_axis_tready,
    input  wire logic                              s_axis_tuser,
    input  wire logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic [psa_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input  wire logic                              m_axis_tuser,
    input  wire logic                              o_cfg_ready
);

    logic fall_accept;

    assign fall_accept = s_axis_tvalid && s_axis_tready && !s_axis_tuser;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output side is ready");

    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(fall_accept, 2))
        else $error("result without a falling edge two cycles earlier");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready && o_cfg_ready)
        else $error("input stalled without output backpressure");

endmodule

bind pwm_sensor_pulse_averager psa_checker u_psa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .o_cfg_ready   (o_cfg_ready)
);

`default_nettype wire
